// ===== src/mpwm_pkg.sv =====
// mpwm_pkg: shared types, codes and sizes for the multichannel pwm generator
// depends on nothing; used by every module under src

package mpwm_pkg;

  localparam int CHANNELS    = 8;
  localparam int CH_IDX_W    = $clog2(CHANNELS);
  localparam int CMD_W       = 2;
  localparam int CHAN_W      = 3;
  localparam int LEVEL_W     = 8;
  localparam int TIME_W      = 16;
  localparam int PIN_W       = 8;
  localparam int FLIP_W      = 32;
  localparam int PROD_W      = LEVEL_W + TIME_W;
  localparam int S_DATA_W    = 32;
  localparam int M_DATA_W    = PIN_W + FLIP_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input command codes
  localparam logic [CMD_W-1:0] CMD_LEVEL  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENABLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // configuration register indexes
  localparam logic REG_PERIOD     = 1'b0;
  localparam logic REG_FULL_SCALE = 1'b1;

  // classified operation kinds handed to the back end
  typedef enum logic [1:0] {
    OP_LEVEL,
    OP_ENABLE,
    OP_TICK,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [CH_IDX_W-1:0]   channel;
    logic [LEVEL_W-1:0]    level;
    logic                  enable;
    logic [TIME_W-1:0]     dt;
  } op_t;

  typedef struct packed {
    logic [TIME_W-1:0]  period;
    logic [LEVEL_W-1:0] full_scale;
  } cfg_t;

  typedef struct packed {
    logic [FLIP_W-1:0] flip_total;
    logic [PIN_W-1:0]  pin_levels;
  } result_t;

endpackage

// ===== src/mpwm_front.sv =====
// mpwm_front: unpacks input items and sorts them into operation kinds
// depends on mpwm_pkg; feeds mpwm_queue

module mpwm_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mpwm_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                          q_full,
  output logic                          push,
  output mpwm_pkg::op_t                 push_op
);

  logic [mpwm_pkg::CMD_W-1:0]  cmd;
  logic [mpwm_pkg::CHAN_W-1:0] chan;
  logic                        chan_ok;

  assign cmd  = s_tdata[1:0];
  assign chan = s_tdata[4:2];
  // channels beyond the implemented count turn level and enable into no-ops
  assign chan_ok = 32'(chan) < mpwm_pkg::CHANNELS;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_op.channel = chan[mpwm_pkg::CH_IDX_W-1:0];
    push_op.level   = s_tdata[12:5];
    push_op.enable  = s_tdata[13];
    push_op.dt      = s_tdata[29:14];
    unique case (cmd)
      mpwm_pkg::CMD_LEVEL:  push_op.kind = chan_ok ? mpwm_pkg::OP_LEVEL  : mpwm_pkg::OP_NOP;
      mpwm_pkg::CMD_ENABLE: push_op.kind = chan_ok ? mpwm_pkg::OP_ENABLE : mpwm_pkg::OP_NOP;
      mpwm_pkg::CMD_TICK:   push_op.kind = mpwm_pkg::OP_TICK;
      default:              push_op.kind = mpwm_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== src/mpwm_queue.sv =====
// mpwm_queue: short fifo of classified operations between front and back end
// depends on mpwm_pkg

module mpwm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mpwm_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output mpwm_pkg::op_t q_op
);

  mpwm_pkg::op_t                 entries [mpwm_pkg::QUEUE_DEPTH];
  logic [mpwm_pkg::QPTR_W-1:0]   wptr;
  logic [mpwm_pkg::QPTR_W-1:0]   rptr;
  logic [mpwm_pkg::QCNT_W-1:0]   count;

  assign full    = count == mpwm_pkg::QCNT_W'(mpwm_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_op    = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/mpwm_back.sv =====
// mpwm_back: channel state, level divider, per-channel tick sweep, result register
// depends on mpwm_pkg; takes operations from mpwm_queue

module mpwm_back (
  input  logic               clk,
  input  logic               rst,
  input  mpwm_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  mpwm_pkg::op_t      q_op,
  output logic               pop,
  output logic               m_valid,
  input  logic               m_ready,
  output mpwm_pkg::result_t  res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_TICK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam int DIV_STEPS = mpwm_pkg::PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  logic [2:0]                        state;
  mpwm_pkg::op_t                     op;
  logic [mpwm_pkg::PROD_W-1:0]       dq;
  logic [mpwm_pkg::LEVEL_W-1:0]      rem;
  logic [STEP_W-1:0]                 step;
  logic [mpwm_pkg::CH_IDX_W-1:0]     tick_ch;

  logic [mpwm_pkg::TIME_W-1:0]       remaining [mpwm_pkg::CHANNELS];
  logic [mpwm_pkg::TIME_W-1:0]       on_time   [mpwm_pkg::CHANNELS];
  logic [mpwm_pkg::CHANNELS-1:0]     is_high;
  logic [mpwm_pkg::CHANNELS-1:0]     active;
  logic [mpwm_pkg::FLIP_W-1:0]       flip_count;

  // divider step
  logic [mpwm_pkg::LEVEL_W:0]        r2;
  logic                              q_bit;
  logic [mpwm_pkg::TIME_W-1:0]       quotient;

  // tick datapath for the channel under the sweep
  logic [mpwm_pkg::TIME_W-1:0]       ht;
  logic [mpwm_pkg::TIME_W-1:0]       left;
  logic [mpwm_pkg::TIME_W-1:0]       excess;
  logic [mpwm_pkg::TIME_W-1:0]       low_len;
  logic [mpwm_pkg::TIME_W-1:0]       phase;
  logic [mpwm_pkg::TIME_W-1:0]       new_rem;
  logic [mpwm_pkg::PIN_W-1:0]        pins;

  assign pop = (state == S_IDLE) && q_valid;

  always_comb begin
    r2       = {rem, dq[mpwm_pkg::PROD_W-1]};
    q_bit    = r2 >= {1'b0, cfg.full_scale};
    quotient = {dq[mpwm_pkg::TIME_W-2:0], q_bit};
  end

  always_comb begin
    ht      = on_time[tick_ch];
    left    = remaining[tick_ch];
    excess  = op.dt - left - 16'd1;
    low_len = (cfg.period > ht) ? cfg.period - ht : '0;
    phase   = is_high[tick_ch] ? low_len : ht;
    new_rem = (phase > excess) ? phase - excess : '0;
  end

  always_comb begin
    pins = '0;
    for (int c = 0; c < mpwm_pkg::PIN_W; c++) begin
      if (c < mpwm_pkg::CHANNELS) begin
        pins[c] = is_high[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op <= q_op;
    end
    unique case (state)
      S_MUL: begin
        dq   <= {{mpwm_pkg::TIME_W{1'b0}}, op.level}
              * {{mpwm_pkg::LEVEL_W{1'b0}}, cfg.period};
        rem  <= '0;
        step <= STEP_W'(DIV_STEPS - 1);
      end
      S_DIV: begin
        rem  <= q_bit ? mpwm_pkg::LEVEL_W'(r2 - {1'b0, cfg.full_scale})
                      : r2[mpwm_pkg::LEVEL_W-1:0];
        dq   <= {dq[mpwm_pkg::PROD_W-2:0], q_bit};
        step <= step - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_ch    <= '0;
      is_high    <= '0;
      active     <= '0;
      flip_count <= '0;
      m_valid    <= 1'b0;
      for (int c = 0; c < mpwm_pkg::CHANNELS; c++) begin
        remaining[c] <= '0;
        on_time[c]   <= '0;
      end
    end else begin
      if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_op.kind)
              mpwm_pkg::OP_LEVEL: begin
                if (q_op.level > cfg.full_scale) begin
                  state <= S_DONE;
                end else if (cfg.full_scale == '0) begin
                  on_time[q_op.channel]   <= '0;
                  remaining[q_op.channel] <= '0;
                  state                   <= S_DONE;
                end else begin
                  state <= S_MUL;
                end
              end
              mpwm_pkg::OP_ENABLE: begin
                active[q_op.channel] <= q_op.enable;
                state                <= S_DONE;
              end
              mpwm_pkg::OP_TICK: begin
                tick_ch <= '0;
                state   <= S_TICK;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == '0) begin
            on_time[op.channel]   <= quotient;
            remaining[op.channel] <= quotient;
            state                 <= S_DONE;
          end
        end
        S_TICK: begin
          if (active[tick_ch]) begin
            if (ht == '0) begin
              is_high[tick_ch] <= 1'b0;
            end else if (ht == cfg.period) begin
              is_high[tick_ch] <= 1'b1;
            end else if (op.dt <= left) begin
              remaining[tick_ch] <= left - op.dt;
            end else begin
              remaining[tick_ch] <= new_rem;
              is_high[tick_ch]   <= !is_high[tick_ch];
              flip_count         <= flip_count + 1'b1;
            end
          end
          if (tick_ch == mpwm_pkg::CH_IDX_W'(mpwm_pkg::CHANNELS - 1)) begin
            state <= S_DONE;
          end else begin
            tick_ch <= tick_ch + 1'b1;
          end
        end
        S_DONE: begin
          if (!m_valid || m_ready) begin
            m_valid        <= 1'b1;
            res.pin_levels <= pins;
            res.flip_total <= flip_count;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // enables only change between commands, never in the middle of a sweep
  a_active_steady: assert property (@(posedge clk) disable iff (rst)
    state == S_TICK |=> $stable(active))
    else $error("channel enables changed during a tick sweep");

  // at most one toggle is counted per cycle
  a_flip_step: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (flip_count == $past(flip_count))
          || (flip_count == $past(flip_count) + 32'd1))
    else $error("flip counter moved by more than one");

  // a finished command waits while the previous result is still held
  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && m_valid && !m_ready |=> state == S_DONE)
    else $error("result overwritten before it was taken");
`endif

endmodule

// ===== src/multichannel_pwm_generator.sv =====
// multichannel_pwm_generator: top level of the software-style pwm block
// depends on mpwm_pkg, mpwm_front, mpwm_queue, mpwm_back
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  s_tdata: cmd, channel, level, enable, dt
//  m_*      out        m_tvalid / m_tready  m_tdata: pin_levels, flip_total
//  cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data (period, full_scale)
//
// every item gives exactly one result; the back end works one item at a time
// level: taken in idle, multiplied, run through the bit-serial divider, then posted
// tick: taken in idle, then a sweep over all 8 channels in turn, then posted
// enable, no-op and dropped level items go from idle straight to posting; a two-entry queue takes items while busy
// synchronous active-high reset clears all channel state, the queue and the result valid flag
// a stalled m_tready holds the result, and the back end waits in its done state; s_tready drops once the queue fills

module multichannel_pwm_generator (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [1:0] cmd, [4:2] channel, [12:5] level, [13] enable, [29:14] dt, [31:30] zero
  input  logic [mpwm_pkg::S_DATA_W-1:0] s_tdata,
  // result items
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] pin_levels, [39:8] flip_total
  output logic [mpwm_pkg::M_DATA_W-1:0] m_tdata,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [mpwm_pkg::TIME_W-1:0]   cfg_data
);

  mpwm_pkg::cfg_t    cfg;
  mpwm_pkg::op_t     push_op;
  mpwm_pkg::op_t     q_op;
  mpwm_pkg::result_t res;
  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              pop;

  // configuration is always accepted; registers reset to their defaults
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period     <= 16'd2000;
      cfg.full_scale <= 8'd255;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mpwm_pkg::REG_PERIOD:     cfg.period     <= cfg_data;
        mpwm_pkg::REG_FULL_SCALE: cfg.full_scale <= cfg_data[mpwm_pkg::LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front end: unpack and classify
  mpwm_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  // decoupling queue
  mpwm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  // back end: channel state and result register
  mpwm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .res     (res)
  );

  assign m_tdata = {res.flip_total, res.pin_levels};

endmodule
